/* hdl/bti_pkg.sv */
package bti_pkg;

  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  localparam int CNT_W   = 6;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 10;
  localparam int FRAC_W  = 17;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  // Input actions.
  localparam logic [1:0] ACT_ROW_BP = 2'd0;
  localparam logic [1:0] ACT_COL_BP = 2'd1;
  localparam logic [1:0] ACT_GRID   = 2'd2;
  localparam logic [1:0] ACT_QUERY  = 2'd3;

  // Configuration register indexes.
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_EDGE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DIV_INIT,
    ST_DIV,
    ST_GRID,
    ST_BLEND_MUL,
    ST_BLEND_ADD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_FIRST,
    RD_LAST,
    RD_MID
  } rd_sel_t;

  typedef struct packed {
    logic       accept;
    rd_sel_t    rd_sel;
    logic       cap_first;
    logic       edge_chk;
    logic       srch_step;
    logic       div_init;
    logic       div_step;
    logic       div_last;
    logic       axis_next;
    logic       grid_cap;
    logic [1:0] corner;
    logic       blend_mul;
    logic       blend_add;
    logic [1:0] blend_sel;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic table_ready;
    logic axis_col;
    logic edge_hit;
    logic srch_done;
    logic div_trivial;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/bilinear_table_interpolator.sv */
// Load transactions are accepted back to back while the controller is idle.
// For each axis a query runs a binary search of at most ceil(log2(count-1))
// steps, then it does the grid reads, blends and output; one query is in
// flight at a time.
// Reset (synchronous, active low) sets both counts to 2 and marks the table not loaded.
module bilinear_table_interpolator #(
  parameter int MAX_ROWS = bti_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = bti_pkg::DEF_MAX_COLS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [9:0]         in_entry_index,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_row_coord,
  input  logic signed [31:0] in_col_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_interp_value,
  output logic               out_not_loaded,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_wdata
);
  import bti_pkg::*;

  // The controller sequences each query: for the row axis and then the
  // column axis it reads the first and last breakpoints, clamps coordinates
  // that fall outside them, otherwise runs a binary search with one
  // breakpoint memory read per step, and then forms the 16-bit fraction
  // with a restoring divider that retires one quotient bit per cycle.
  // The four corner grid values are then read from the grid memory and
  // blended by one shared multiplier: rows first, then columns.
  //
  // The result sits in an output register, so a new transaction can be
  // accepted while the previous result waits for the consumer. Load
  // transactions write the breakpoint or grid memories directly.

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bti_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bti_datapath #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_action       (in_action),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_row_coord    (in_row_coord),
    .in_col_coord    (in_col_coord),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_interp_value(out_interp_value),
    .out_not_loaded  (out_not_loaded)
  );

endmodule

/* hdl/bti_ram.sv */
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/bti_datapath.sv */
module bti_datapath #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bti_pkg::ctrl_cmd_t       cmd,
  output bti_pkg::dp_status_t      status,
  input  logic [1:0]               in_action,
  input  logic [9:0]               in_entry_index,
  input  logic signed [31:0]       in_entry_value,
  input  logic signed [31:0]       in_row_coord,
  input  logic signed [31:0]       in_col_coord,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [5:0]               cfg_wdata,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [31:0]       out_interp_value,
  output logic                     out_not_loaded
);
  import bti_pkg::*;

  localparam int MAXN   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int IW     = $clog2(MAXN);
  localparam int CW     = $clog2(MAXN + 1);
  localparam int RAW    = $clog2(MAX_ROWS);
  localparam int CAW    = $clog2(MAX_COLS);
  localparam int GDEPTH = MAX_ROWS * MAX_COLS;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int GPW    = $clog2(GDEPTH + 1);

  // Control registers.
  logic [5:0] row_count_r, col_count_r;
  logic       table_ready_r, table_ready_nxt;
  logic       out_valid_r;

  // Payload registers.
  logic signed [31:0] xr_r, xc_r;
  logic               nl_r;
  logic               axis_r;
  logic [IW-1:0]      a_r, b_r;
  logic signed [31:0] a_val_r, b_val_r;
  logic [IW-1:0]      lo_r [2];
  logic [IW-1:0]      hi_r [2];
  logic [FRAC_W-1:0]  frac_r [2];
  logic [32:0]        rem_r, wid_r;
  logic [15:0]        q_r;
  logic signed [31:0] p_r [4];
  logic signed [50:0] prod_r;
  logic signed [31:0] base_r, xp1_r, xp2_r, res_r;
  logic signed [31:0] out_interp_r;
  logic               out_nl_r;

  logic [CW-1:0] nr, nc, n_sel;
  logic signed [31:0] x_sel, bp_rdata, row_rdata, col_rdata, grid_rdata;
  logic [IW-1:0] bp_idx, mid;
  logic [IW:0]   idx_sum;
  logic          edge_lo, edge_hi;
  logic signed [32:0] iv_width, iv_diff;
  logic          div_zero, div_full;
  logic [33:0]   rem2;
  logic          q_bit;
  logic [15:0]   q_nxt;
  logic [32:0]   rem_nxt;
  logic [IW-1:0] g_row, g_col;
  logic [GAW-1:0] grid_raddr;
  logic          row_we, col_we, grid_we;
  logic signed [31:0] bl_a, bl_b;
  logic [FRAC_W-1:0]  bl_f;
  logic signed [32:0] bl_diff;
  logic signed [51:0] bl_sum;
  logic signed [35:0] bl_rnd;
  logic signed [31:0] bl_sat;

  always_comb begin
    if (row_count_r < 6'd2) begin
      nr = CW'(2);
    end else if (int'(row_count_r) > MAX_ROWS) begin
      nr = CW'(MAX_ROWS);
    end else begin
      nr = CW'(row_count_r);
    end
    if (col_count_r < 6'd2) begin
      nc = CW'(2);
    end else if (int'(col_count_r) > MAX_COLS) begin
      nc = CW'(MAX_COLS);
    end else begin
      nc = CW'(col_count_r);
    end
  end

  // Load transactions write the stores in the cycle they are accepted.
  assign row_we  = cmd.accept && (in_action == ACT_ROW_BP) &&
                   (int'(in_entry_index) < MAX_ROWS);
  assign col_we  = cmd.accept && (in_action == ACT_COL_BP) &&
                   (int'(in_entry_index) < MAX_COLS);
  assign grid_we = cmd.accept && (in_action == ACT_GRID) &&
                   (int'(in_entry_index) < GDEPTH);

  always_comb begin
    table_ready_nxt = table_ready_r;
    if (cfg_we) begin
      table_ready_nxt = 1'b0;
    end else if (grid_we &&
                 (GPW'(in_entry_index) == GPW'(GPW'(nr) * GPW'(nc) - GPW'(1)))) begin
      table_ready_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= 6'd2;
      col_count_r   <= 6'd2;
      table_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_ROW_COUNT)) begin
        row_count_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == REG_COL_COUNT)) begin
        col_count_r <= cfg_wdata;
      end
      table_ready_r <= table_ready_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  bti_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_row_ram (
    .clk  (clk),
    .we   (row_we),
    .waddr(RAW'(in_entry_index)),
    .wdata(in_entry_value),
    .raddr(RAW'(bp_idx)),
    .rdata(row_rdata)
  );

  bti_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLS)) u_col_ram (
    .clk  (clk),
    .we   (col_we),
    .waddr(CAW'(in_entry_index)),
    .wdata(in_entry_value),
    .raddr(CAW'(bp_idx)),
    .rdata(col_rdata)
  );

  bti_ram #(.WIDTH(VAL_W), .DEPTH(GDEPTH)) u_grid_ram (
    .clk  (clk),
    .we   (grid_we),
    .waddr(GAW'(in_entry_index)),
    .wdata(in_entry_value),
    .raddr(grid_raddr),
    .rdata(grid_rdata)
  );

  // Search for the active axis.
  assign n_sel    = axis_r ? nc : nr;
  assign x_sel    = axis_r ? xc_r : xr_r;
  assign bp_rdata = axis_r ? col_rdata : row_rdata;
  assign idx_sum  = {1'b0, a_r} + {1'b0, b_r};
  assign mid      = idx_sum[IW:1];

  always_comb begin
    case (cmd.rd_sel)
      RD_FIRST: bp_idx = '0;
      RD_LAST:  bp_idx = IW'(n_sel - CW'(1));
      RD_MID:   bp_idx = mid;
      default:  bp_idx = '0;
    endcase
  end

  assign edge_lo  = (x_sel <= a_val_r);
  assign edge_hi  = (x_sel >= bp_rdata);
  assign iv_width = 33'(b_val_r) - 33'(a_val_r);
  assign iv_diff  = 33'(x_sel) - 33'(a_val_r);
  assign div_zero = (iv_width <= 33'sd0) || (iv_diff <= 33'sd0);
  assign div_full = (iv_diff >= iv_width);

  // One restoring division step per cycle.
  assign rem2    = {rem_r, 1'b0};
  assign q_bit   = (rem2 >= {1'b0, wid_r});
  assign rem_nxt = q_bit ? 33'(rem2 - {1'b0, wid_r}) : rem2[32:0];
  assign q_nxt   = {q_r[14:0], q_bit};

  // Corner order: (lo,lo), (lo,hi), (hi,lo), (hi,hi) as (row,col).
  assign g_row      = cmd.corner[1] ? hi_r[0] : lo_r[0];
  assign g_col      = cmd.corner[0] ? hi_r[1] : lo_r[1];
  assign grid_raddr = GAW'(GPW'(g_row) * GPW'(nc) + GPW'(g_col));

  always_comb begin
    case (cmd.blend_sel)
      2'd0: begin
        bl_a = p_r[0];
        bl_b = p_r[2];
        bl_f = frac_r[0];
      end
      2'd1: begin
        bl_a = p_r[1];
        bl_b = p_r[3];
        bl_f = frac_r[0];
      end
      default: begin
        bl_a = xp1_r;
        bl_b = xp2_r;
        bl_f = frac_r[1];
      end
    endcase
  end

  assign bl_diff = 33'(bl_b) - 33'(bl_a);
  assign bl_sum  = {{4{base_r[31]}}, base_r, 16'b0} + 52'(prod_r) + 52'sd32768;
  assign bl_rnd  = bl_sum[51:16];
  always_comb begin
    if ((bl_rnd[35:31] == 5'b00000) || (bl_rnd[35:31] == 5'b11111)) begin
      bl_sat = bl_rnd[31:0];
    end else if (bl_rnd[35]) begin
      bl_sat = 32'sh8000_0000;
    end else begin
      bl_sat = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_action == ACT_QUERY)) begin
      xr_r   <= in_row_coord;
      xc_r   <= in_col_coord;
      nl_r   <= !table_ready_r;
      axis_r <= 1'b0;
    end
    if (cmd.axis_next) begin
      axis_r <= 1'b1;
    end
    if (cmd.cap_first) begin
      a_val_r <= bp_rdata;
    end
    if (cmd.edge_chk) begin
      if (edge_lo) begin
        lo_r[axis_r]   <= '0;
        hi_r[axis_r]   <= IW'(1);
        frac_r[axis_r] <= '0;
      end else if (edge_hi) begin
        lo_r[axis_r]   <= IW'(n_sel - CW'(2));
        hi_r[axis_r]   <= IW'(n_sel - CW'(1));
        frac_r[axis_r] <= FRAC_ONE;
      end else begin
        a_r     <= '0;
        b_r     <= IW'(n_sel - CW'(1));
        b_val_r <= bp_rdata;
      end
    end
    if (cmd.srch_step) begin
      if (x_sel < bp_rdata) begin
        b_r     <= mid;
        b_val_r <= bp_rdata;
      end else begin
        a_r     <= mid;
        a_val_r <= bp_rdata;
      end
    end
    if (cmd.div_init) begin
      lo_r[axis_r] <= a_r;
      hi_r[axis_r] <= b_r;
      rem_r        <= iv_diff;
      wid_r        <= iv_width;
      q_r          <= '0;
      if (div_zero) begin
        frac_r[axis_r] <= '0;
      end else if (div_full) begin
        frac_r[axis_r] <= FRAC_ONE;
      end
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      if (cmd.div_last) begin
        frac_r[axis_r] <= {1'b0, q_nxt};
      end
    end
    if (cmd.grid_cap) begin
      p_r[cmd.corner - 2'd1] <= grid_rdata;
    end
    if (cmd.blend_mul) begin
      prod_r <= $signed({1'b0, bl_f}) * bl_diff;
      base_r <= bl_a;
    end
    if (cmd.blend_add) begin
      case (cmd.blend_sel)
        2'd0:    xp1_r <= bl_sat;
        2'd1:    xp2_r <= bl_sat;
        default: res_r <= bl_sat;
      endcase
    end
    if (cmd.out_load) begin
      out_interp_r <= nl_r ? 32'sd0 : res_r;
      out_nl_r     <= nl_r;
    end
  end

  assign status.table_ready = table_ready_r;
  assign status.axis_col    = axis_r;
  assign status.edge_hit    = edge_lo || edge_hi;
  assign status.srch_done   = (({1'b0, b_r} - {1'b0, a_r}) <= (IW+1)'(1));
  assign status.div_trivial = div_zero || div_full;
  assign status.out_free    = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_interp_value = out_interp_r;
  assign out_not_loaded   = out_nl_r;

endmodule

/* hdl/bti_controller.sv */
module bti_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_action,
  output logic                in_ready,
  input  bti_pkg::dp_status_t status,
  output bti_pkg::ctrl_cmd_t  cmd
);
  import bti_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  state_t     axis_done_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // After the row axis the column axis is searched, then the grid is read.
  assign axis_done_state = status.axis_col ? ST_GRID : ST_RD_FIRST;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rd_sel = RD_FIRST;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_action == ACT_QUERY) begin
            state_nxt = status.table_ready ? ST_RD_FIRST : ST_OUT;
          end
        end
      end
      ST_RD_FIRST: begin
        cmd.rd_sel = RD_FIRST;
        state_nxt  = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        cmd.rd_sel    = RD_LAST;
        cmd.cap_first = 1'b1;
        state_nxt     = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.edge_chk = 1'b1;
        if (status.edge_hit) begin
          cmd.axis_next = !status.axis_col;
          cnt_nxt       = '0;
          state_nxt     = axis_done_state;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (status.srch_done) begin
          state_nxt = ST_DIV_INIT;
        end else begin
          cmd.rd_sel = RD_MID;
          state_nxt  = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd.rd_sel    = RD_MID;
        cmd.srch_step = 1'b1;
        state_nxt     = ST_SRCH_RD;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        if (status.div_trivial) begin
          cmd.axis_next = !status.axis_col;
          state_nxt     = axis_done_state;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (cnt_r == 5'd15);
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          cmd.axis_next = !status.axis_col;
          cnt_nxt       = '0;
          state_nxt     = axis_done_state;
        end
      end
      ST_GRID: begin
        cmd.corner   = cnt_r[1:0];
        cmd.grid_cap = (cnt_r != 5'd0);
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'd4) begin
          cnt_nxt   = '0;
          state_nxt = ST_BLEND_MUL;
        end
      end
      ST_BLEND_MUL: begin
        cmd.blend_mul = 1'b1;
        cmd.blend_sel = cnt_r[1:0];
        state_nxt     = ST_BLEND_ADD;
      end
      ST_BLEND_ADD: begin
        cmd.blend_add = 1'b1;
        cmd.blend_sel = cnt_r[1:0];
        if (cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = ST_BLEND_MUL;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
